FILE: rtl/core/pmq_pkg.sv
// pmq_pkg: shared types and constants for the priority message queue
// used by pmq_cell, pmq_chain and priority_message_queue; no dependencies
package pmq_pkg;

    localparam int DEPTH     = 16;
    localparam int MSG_BYTES = 4;

    localparam int PRI_W   = 8;
    localparam int PAY_W   = 32;
    localparam int CFG_W   = 5;
    localparam int FIELD_W = 5;   // width of queue_level and free_space fields
    localparam int STORE_W = (MSG_BYTES * 8 > PAY_W) ? PAY_W : MSG_BYTES * 8;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

    localparam logic REQ_PUT = 1'b0;
    localparam logic REQ_GET = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // contents of one slot of the sorted chain
    typedef struct packed {
        logic               valid;
        logic [PRI_W-1:0]   pri;
        logic [STORE_W-1:0] payload;
    } slot_t;

    // request broadcast to every cell
    typedef struct packed {
        logic               put;
        logic               get;
        logic [PRI_W-1:0]   pri;
        logic [STORE_W-1:0] payload;
    } cmd_t;

endpackage

FILE: rtl/core/pmq_cell.sv
// pmq_cell: one slot of the sorted chain, inserts, shifts right on put, left on get
// depends on pmq_pkg
module pmq_cell
    import pmq_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  cmd_t  cmd,
    input  logic  left_after,   // new word goes after the left neighbor
    input  slot_t left_slot,
    input  slot_t right_slot,
    output logic  after,        // new word goes after this cell
    output slot_t slot
);

    slot_t slot_reg;
    slot_t slot_next;

    // sorted descending and valid as a prefix, so this is a prefix too;
    // equal priority stays ahead of the new word
    assign after = slot_reg.valid && (slot_reg.pri >= cmd.pri);
    assign slot  = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (cmd.put) begin
            if (after) begin
                slot_next = slot_reg;
            end else if (left_after) begin
                slot_next.valid   = 1'b1;
                slot_next.pri     = cmd.pri;
                slot_next.payload = cmd.payload;
            end else begin
                slot_next = left_slot;
            end
        end else if (cmd.get) begin
            slot_next = right_slot;
        end
    end

    // only the valid mark is reset, the data follows it
    always_ff @(posedge aclk) begin
        slot_reg.pri     <= slot_next.pri;
        slot_reg.payload <= slot_next.payload;
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
    end

endmodule

FILE: rtl/core/pmq_chain.sv
// pmq_chain: row of DEPTH cells, slot 0 holds the next word to leave
// depends on pmq_pkg and pmq_cell
module pmq_chain
    import pmq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    output slot_t            head,
    output logic [DEPTH-1:0] valid_vec
);

    slot_t slots [DEPTH];
    logic  afters [DEPTH];
    slot_t empty_slot;

    always_comb begin
        empty_slot         = '0;
        empty_slot.payload = '0;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic  l_after;
        slot_t l_slot;
        slot_t r_slot;

        if (i == 0) begin : g_first
            assign l_after = 1'b1;
            assign l_slot  = empty_slot;
        end else begin : g_mid
            assign l_after = afters[i-1];
            assign l_slot  = slots[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_slot = empty_slot;
        end else begin : g_inner
            assign r_slot = slots[i+1];
        end

        pmq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_after (l_after),
            .left_slot  (l_slot),
            .right_slot (r_slot),
            .after      (afters[i]),
            .slot       (slots[i])
        );

        assign valid_vec[i] = slots[i].valid;
    end

    assign head = slots[0];

endmodule

FILE: rtl/core/priority_message_queue.sv
// priority_message_queue: top level, bounded queue ordered by priority
// depends on pmq_pkg and pmq_chain (which uses pmq_cell)
//
//  channel  dir  handshake               contents
//  s_       in   s_tvalid / s_tready     tuser: req_type; tdata: priority_req, payload_in
//  m_       out  m_tvalid / m_tready     tuser: status; tdata: payload, priority, count, free
//  cfg_     in   cfg_valid / cfg_ready   cfg_data: capacity_limit
//
// one request per cycle while m_ takes each result: the whole chain inserts or removes at once,
// each cell looks only at its two neighbors and the broadcast request
// the result word sits in an output register; a new request is taken in the same
// cycle the previous result is taken, so a stalled m_ side stalls s_ after one word
// reset clears all valid marks and the count, capacity_limit returns to 16
// cfg_ready is always high
module priority_message_queue
    import pmq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] priority_req, [39:8] payload_in
    input  logic [0:0]  s_tuser,   // [0] req_type
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] payload_out, [39:32] priority_out,
                                   // [44:40] queue_level, [49:45] free_space, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // capacity limit register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    // request decode
    logic               s_fire;
    logic               req_kind;
    logic [PRI_W-1:0]   req_pri;
    logic [PAY_W-1:0]   req_pay;

    // state
    logic [CFG_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   held_reg;
    logic [CNT_W-1:0]   held_next;

    // output register
    logic               m_valid_reg;
    logic [55:0]        m_data_reg;
    logic [55:0]        m_data_next;
    status_t            m_stat_reg;
    status_t            m_stat_next;

    // effective limit and derived flags
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   lim_ext;
    logic [CNT_W-1:0]   lim;
    logic               is_full;
    logic               is_empty;
    logic [CNT_W-1:0]   free_next;

    cmd_t               cmd;
    slot_t              head;
    logic [DEPTH-1:0]   valid_vec;

    assign req_kind = s_tuser[0];
    assign req_pri  = s_tdata[7:0];
    assign req_pay  = s_tdata[39:8];

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // clamp limit to 1..DEPTH
    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            lim_ext = CMP_W'(1);
        end else if (cap_ext > CMP_W'(DEPTH)) begin
            lim_ext = CMP_W'(DEPTH);
        end else begin
            lim_ext = cap_ext;
        end
        lim = CNT_W'(lim_ext);
    end

    assign is_full  = (held_reg >= lim) || (held_reg >= CNT_W'(DEPTH));
    assign is_empty = (held_reg == '0);

    // broadcast to the chain, only for requests that change it
    always_comb begin
        cmd.put     = s_fire && (req_kind == REQ_PUT) && !is_full;
        cmd.get     = s_fire && (req_kind == REQ_GET) && !is_empty;
        cmd.pri     = req_pri;
        cmd.payload = req_pay[STORE_W-1:0];
    end

    pmq_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .head      (head),
        .valid_vec (valid_vec)
    );

    // count after this request and result word
    always_comb begin
        held_next = held_reg;
        if (cmd.put) begin
            held_next = held_reg + CNT_W'(1);
        end else if (cmd.get) begin
            held_next = held_reg - CNT_W'(1);
        end

        free_next = (held_next < lim) ? (lim - held_next) : '0;

        m_stat_next = ST_OK;
        if (req_kind == REQ_PUT) begin
            if (is_full) begin
                m_stat_next = ST_FULL;
            end
        end else if (is_empty) begin
            m_stat_next = ST_EMPTY;
        end

        m_data_next = '0;
        if (cmd.get) begin
            m_data_next[31:0]  = PAY_W'(head.payload);
            m_data_next[39:32] = head.pri;
        end
        m_data_next[44:40] = FIELD_W'(held_next);
        m_data_next[49:45] = FIELD_W'(free_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_stat_reg  <= ST_OK;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            held_reg <= held_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
                m_stat_reg  <= m_stat_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_stat_reg;

`ifndef NO_ASSERTIONS
    // valid marks always form a prefix whose length is the count
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ($countones(valid_vec) == 32'(held_reg)) &&
        ((valid_vec & (valid_vec + DEPTH'(1))) == '0))
        else $error("valid marks disagree with held count");

    // a put refused for a full queue reports full and leaves the count
    a_full_put: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (req_kind == REQ_PUT) && is_full) |=>
        (m_tvalid && (m_tuser == ST_FULL) && $stable(held_reg)))
        else $error("refused put changed the queue or misreported");

    // a waiting result reports the count the queue now holds
    a_count_field: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[44:40] == FIELD_W'(held_reg)))
        else $error("queue level field does not match held count");
`endif

endmodule
